FILE: hw/rtl/rgcd_pkg.sv
package rgcd_pkg;

  // Default operand width
  localparam int unsigned DataWidthDefault = 32;

  // Control flags from the step unit to the sequencer
  typedef struct packed {
    logic fin;    // operands settled: a holds the gcd with the common factors of two removed
    logic inc_k;  // both operands were even: one more common factor of two
  } step_ctl_t;

endpackage

FILE: hw/rtl/rgcd_step.sv
module rgcd_step #(
  parameter int unsigned DATA_WIDTH = rgcd_pkg::DataWidthDefault
) (
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output logic [DATA_WIDTH-1:0] a_o,
  output logic [DATA_WIDTH-1:0] b_o,
  output rgcd_pkg::step_ctl_t   ctl_o
);

  logic                  a_gt_b;
  logic [DATA_WIDTH-1:0] big;
  logic [DATA_WIDTH-1:0] sml;
  logic [DATA_WIDTH-1:0] diff;

  assign a_gt_b = (a_i > b_i);
  assign big    = a_gt_b ? a_i : b_i;
  assign sml    = a_gt_b ? b_i : a_i;
  assign diff   = big - sml;

  // One binary-gcd step: finish on a zero or equal operand, else strip a factor of two or halve the odd difference
  always_comb begin
    a_o         = a_i;
    b_o         = b_i;
    ctl_o.fin   = 1'b0;
    ctl_o.inc_k = 1'b0;
    if ((a_i == '0) || (b_i == '0) || (a_i == b_i)) begin
      // zero operand yields the other one; equal operands are the answer
      a_o       = a_i | b_i;
      ctl_o.fin = 1'b1;
    end else if (!a_i[0] && !b_i[0]) begin
      a_o         = a_i >> 1;
      b_o         = b_i >> 1;
      ctl_o.inc_k = 1'b1;
    end else if (!a_i[0]) begin
      a_o = a_i >> 1;
    end else if (!b_i[0]) begin
      b_o = b_i >> 1;
    end else if (a_gt_b) begin
      a_o = diff >> 1;
    end else begin
      b_o = diff >> 1;
    end
  end

endmodule

FILE: hw/rtl/rgcd_core.sv
module rgcd_core #(
  parameter int unsigned DATA_WIDTH = rgcd_pkg::DataWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  go_i,
  input  logic [DATA_WIDTH-1:0] op_a_i,
  input  logic [DATA_WIDTH-1:0] op_b_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] result_o
);

  localparam int unsigned KW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRun   = 2'd1;
  localparam logic [1:0] StShift = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [DATA_WIDTH-1:0] a_q, a_d;
  logic [DATA_WIDTH-1:0] b_q, b_d;
  logic [KW-1:0]         k_q, k_d;

  logic [DATA_WIDTH-1:0] step_a;
  logic [DATA_WIDTH-1:0] step_b;
  rgcd_pkg::step_ctl_t   step_ctl;

  rgcd_step #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_step (
    .a_i  (a_q),
    .b_i  (b_q),
    .a_o  (step_a),
    .b_o  (step_b),
    .ctl_o(step_ctl)
  );

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    done_o  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (go_i) begin
          a_d     = op_a_i;
          b_d     = op_b_i;
          k_d     = '0;
          state_d = StRun;
        end
      end
      StRun: begin
        a_d = step_a;
        b_d = step_b;
        if (step_ctl.inc_k) begin
          k_d = k_q + KW'(1);
        end
        if (step_ctl.fin) begin
          state_d = StShift;
        end
      end
      StShift: begin
        // restore the common factors of two, one per cycle
        if (k_q == '0) begin
          done_o  = 1'b1;
          state_d = StIdle;
        end else begin
          a_d = a_q << 1;
          k_d = k_q - KW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
  end

  assign busy_o   = (state_q != StIdle);
  assign result_o = a_q;

endmodule

FILE: hw/rtl/running_gcd_reduction_top.sv
// Channel  | Direction | Ports                         | Handshake
// ---------+-----------+-------------------------------+------------------------------
// item in  | input     | value_i, last_item_i          | taken when start && !busy
// result   | output    | gcd_result_o                  | one-cycle strobe gcd_valid_o
//
// The first item of a sequence is loaded directly and busy stays low.
// A later item runs the binary-gcd sequencer: one subtract-or-shift step per
// cycle, then a left shift per common factor of two; busy is high throughout.
// The result strobe for the last item is registered from the core's done flag.
// Reset is asynchronous and active low; the result side cannot stall.
module running_gcd_reduction_top #(
  parameter int unsigned DATA_WIDTH = rgcd_pkg::DataWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic                  last_item_i,
  output logic                  gcd_valid_o,
  output logic [DATA_WIDTH-1:0] gcd_result_o
);

  logic                  started_q;
  logic                  last_q;
  logic                  valid_q;
  logic [DATA_WIDTH-1:0] running_q;
  logic [DATA_WIDTH-1:0] result_q;

  logic                  accept;
  logic                  core_go;
  logic                  core_busy;
  logic                  core_done;
  logic [DATA_WIDTH-1:0] core_result;

  assign accept  = start && !core_busy;
  assign core_go = accept && started_q;

  rgcd_core #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (core_go),
    .op_a_i  (running_q),
    .op_b_i  (value_i),
    .busy_o  (core_busy),
    .done_o  (core_done),
    .result_o(core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      last_q    <= 1'b0;
      valid_q   <= 1'b0;
      running_q <= '0;
    end else begin
      valid_q <= 1'b0;
      if (accept && !started_q) begin
        // first item loads the running value, or is the result if it is also the last
        if (last_item_i) begin
          valid_q   <= 1'b1;
          running_q <= '0;
        end else begin
          started_q <= 1'b1;
          running_q <= value_i;
        end
      end else if (core_go) begin
        last_q <= last_item_i;
      end else if (core_done) begin
        if (last_q) begin
          valid_q   <= 1'b1;
          started_q <= 1'b0;
          running_q <= '0;
        end else begin
          running_q <= core_result;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !started_q) begin
      result_q <= value_i;
    end else if (core_done) begin
      result_q <= core_result;
    end
  end

  assign busy         = core_busy;
  assign gcd_valid_o  = valid_q;
  assign gcd_result_o = result_q;

endmodule

FILE: hw/rtl/rgcd_checker.sv
module rgcd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic last_item_i,
  input logic gcd_valid_o
);

  // Busy only rises after an item was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted item");

  // No result is shown while a gcd is still being worked out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !gcd_valid_o)
    else $error("result strobe while busy");

  // A result follows either a finished run or a directly accepted last item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_valid_o |-> ($fell(busy) || $past(start && !busy && last_item_i)))
    else $error("result strobe without cause");

endmodule

bind running_gcd_reduction_top rgcd_checker u_rgcd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .last_item_i(last_item_i),
  .gcd_valid_o(gcd_valid_o)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned DW = rgcd_pkg::DataWidthDefault;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 4 * DW + 64;
  localparam int unsigned RANDOM_ITEMS = 750;

  typedef struct packed {
    logic [DW-1:0] value;
    logic          is_last;
  } gcd_item_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [DW-1:0] value_i = '0;
  logic          last_item_i = 1'b0;
  logic          gcd_valid_o;
  logic [DW-1:0] gcd_result_o;

  gcd_item_t     pending_q[$];
  logic [DW-1:0] expected_gcd_q[$];
  logic [DW-1:0] running_gcd = '0;
  logic          seq_open = 1'b0;
  int            total_items = 0;
  int            items_accepted = 0;
  int            error_count = 0;
  int            idle_cycles = 0;
  int            gap_left = 0;
  int            burst_left = 4;

  running_gcd_reduction_top #(
    .DATA_WIDTH(DW)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .last_item_i (last_item_i),
    .gcd_valid_o (gcd_valid_o),
    .gcd_result_o(gcd_result_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [DW-1:0] gcd_of(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW-1:0] r;
    while (b != '0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Fold one accepted item into the running gcd; close the sequence on the last item.
  task automatic fold_item(input logic [DW-1:0] v, input logic is_last);
    if (!seq_open) running_gcd = v;
    else running_gcd = gcd_of(running_gcd, v);
    seq_open = 1'b1;
    if (is_last) begin
      expected_gcd_q.push_back(running_gcd);
      running_gcd = '0;
      seq_open = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic queue_item(input logic [DW-1:0] v, input logic is_last);
    gcd_item_t itm;
    itm.value = v;
    itm.is_last = is_last;
    pending_q.push_back(itm);
    total_items++;
  endtask

  function automatic logic [DW-1:0] multiple_of(input logic [DW-1:0] g);
    logic [DW-1:0] m_max;
    m_max = {DW{1'b1}} / g;
    return g * DW'($urandom_range(m_max, 0));
  endfunction

  // Build one sequence: mostly multiples of a shared factor, some noise and zeros.
  task automatic queue_sequence();
    int            len;
    int            flavor;
    int            w;
    logic [DW-1:0] g;
    logic [DW-1:0] v;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
    flavor = $urandom_range(0, 9);
    w = $urandom_range(1, DW);
    g = DW'($urandom) >> (DW - w);
    if (flavor >= 7) g = DW'(1) << $urandom_range(0, DW - 1);
    if (g == '0) g = DW'(1);
    for (int i = 0; i < len; i++) begin
      if (flavor == 0) v = DW'($urandom);
      else if ($urandom_range(0, 11) == 0) v = '0;
      else v = multiple_of(g);
      queue_item(v, i == len - 1);
    end
  endtask

  initial begin
    // Single-item sequences pass the item straight through.
    queue_item('0, 1'b1);
    queue_item({DW{1'b1}}, 1'b1);
    queue_item(32'd1, 1'b1);
    // Zero operands.
    queue_item('0, 1'b0);
    queue_item('0, 1'b1);
    queue_item('0, 1'b0);
    queue_item(32'd12, 1'b1);
    queue_item(32'd18, 1'b0);
    queue_item('0, 1'b1);
    queue_item({DW{1'b1}}, 1'b0);
    queue_item({{(DW-1){1'b1}}, 1'b0}, 1'b1);
    queue_item(32'h8000_0000, 1'b0);
    queue_item(32'h4000_0000, 1'b1);
    // Consecutive Fibonacci numbers: longest Euclid chain.
    queue_item(32'hB119_24E1, 1'b0);
    queue_item(32'h6D73_E55F, 1'b1);
    queue_item({DW{1'b1}}, 1'b0);
    queue_item(32'h0000_FFFF, 1'b1);
    queue_item(32'hAAAA_AAAA, 1'b0);
    queue_item(32'h5555_5555, 1'b1);
    queue_item(32'd48, 1'b0);
    queue_item(32'd180, 1'b0);
    queue_item('0, 1'b0);
    queue_item(32'd36, 1'b1);
    while (total_items < RANDOM_ITEMS) queue_sequence();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_accepted < total_items) @(posedge clk_i);
    while (expected_gcd_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("running_gcd_reduction_top regression: pass");
    end else begin
      $display("running_gcd_reduction_top regression: fail");
    end
    $finish;
  end

  always @(posedge clk_i) begin : drive_items
    gcd_item_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        fold_item(value_i, last_item_i);
        items_accepted++;
      end
      // Hold the offered item while the block is busy.
      if (!(start && busy)) begin
        if (gap_left > 0 || pending_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          start <= 1'b0;
        end else begin
          nxt = pending_q.pop_front();
          start <= 1'b1;
          value_i <= nxt.value;
          last_item_i <= nxt.is_last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 64 : 8);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    logic [DW-1:0] want;
    if (rst_ni && gcd_valid_o) begin
      if (expected_gcd_q.size() == 0) begin
        report_mismatch("unexpected gcd_result", gcd_result_o, '0);
      end else begin
        want = expected_gcd_q.pop_front();
        if (gcd_result_o !== want) report_mismatch("gcd_result", gcd_result_o, want);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || gcd_valid_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout at %0t: no item or result moved for %0d cycles",
                 $realtime, IDLE_LIMIT);
        $display("running_gcd_reduction_top regression: fail");
        $finish;
      end
    end
  end

endmodule

FILE: filelist.f
hw/rtl/rgcd_pkg.sv
hw/rtl/rgcd_step.sv
hw/rtl/rgcd_core.sv
hw/rtl/running_gcd_reduction_top.sv
hw/rtl/rgcd_checker.sv
sim/tb.sv
